FILE: hw/rtl/sts_pkg.sv
// Shared constants, types and the key compare for the sorted key table.
package sts_pkg;

   localparam int CAPACITY     = 64;
   localparam int KEY_BITS     = 32;
   localparam int LINEAR_LIMIT = 10;
   localparam int IDX_W        = $clog2(CAPACITY);
   localparam int CNT_W        = IDX_W + 1;

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   localparam logic       ACT_INSERT    = 1'b0;
   localparam logic       ACT_FIND      = 1'b1;
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_MISS   = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam key_type SIGN_MASK = key_type'(1) << (KEY_BITS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_PREP,
      S_SHIFT,
      S_WRITE_KEY,
      S_LIN,
      S_PROBE_ISSUE,
      S_PROBE_CHK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      key_type data;
   } ram_wr_type;

   // a > b, two's complement when sgn is set
   function automatic logic key_greater(key_type a, key_type b, logic sgn);
      key_type fa;
      key_type fb;
      fa = sgn ? (a ^ SIGN_MASK) : a;
      fb = sgn ? (b ^ SIGN_MASK) : b;
      return fa > fb;
   endfunction

endpackage

FILE: hw/rtl/sts_if.sv
// Valid/ready channel interfaces: request, response and control register write.
interface sts_req_if import sts_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    action;
   key_type key;

   modport source (output valid, action, key, input ready);
   modport sink   (input valid, action, key, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       found;
   idx_type    position;
   logic [1:0] status;
   cnt_type    entries;

   modport source (output valid, found, position, status, entries, input ready);
   modport sink   (input valid, found, position, status, entries, output ready);
endinterface

interface sts_csr_if ();
   logic valid;
   logic ready;
   logic signed_keys;

   modport source (output valid, signed_keys, input ready);
   modport sink   (input valid, signed_keys, output ready);
endinterface

FILE: hw/rtl/sts_key_ram.sv
// Key store: one write port, one read port, registered read data.
module sts_key_ram import sts_pkg::*; (
   input  logic       clock,
   input  idx_type    rd_addr,
   output key_type    rd_data,
   input  ram_wr_type wr
);

   key_type mem_ff [CAPACITY];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sorted_table_insert_search_top.sv
// Sorted key table top level: request sequencer, result register, key store.
// Insert scans for the first entry not below the key, moves entries from there up one slot via
// the one RAM port, writes the key; a key that goes on the end moves none. Find: linear scan
// below 10 entries, else binary probe, a read then a check per probe. Full insert or empty find
// go straight to RESP. One at a time: next request taken once the result is registered; a
// result waiting on the sink stalls RESP. Reset clears count, signedness, sequencer, RAM not.
module sorted_table_insert_search_top import sts_pkg::*; (
   input logic        clock,
   input logic        reset,
   sts_req_if.sink    req_chan,
   sts_rsp_if.source  rsp_chan,
   sts_csr_if.sink    csr_chan
);

   // sequencer state
   state_type  state_ff, state_in;
   key_type    key_ff, key_in;
   idx_type    idx_ff, idx_in;
   cnt_type    at_ff, at_in;
   cnt_type    ptr_ff, ptr_in;
   cnt_type    lo_ff, lo_in;
   cnt_type    span_ff, span_in;
   cnt_type    mid_ff, mid_in;
   logic       single_ff, single_in;
   cnt_type    count_ff, count_in;
   logic       signed_ff, signed_in;

   // pending result
   logic       res_found_ff, res_found_in;
   idx_type    res_pos_ff, res_pos_in;
   logic [1:0] res_status_ff, res_status_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff, rsp_found_in;
   idx_type    rsp_pos_ff, rsp_pos_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   cnt_type    rsp_entries_ff, rsp_entries_in;

   // RAM side
   idx_type    rd_addr;
   key_type    rd_data;
   ram_wr_type ram_wr;

   // decode
   logic       req_beat;
   logic       out_free;
   logic       key_le;
   logic       key_eq;
   logic       data_gt;
   logic       idx_last;
   cnt_type    half;
   cnt_type    span_left;

   sts_key_ram u_key_ram (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (ram_wr)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // control register: always ready; the user must write it only while idle, the block does not enforce it
   assign csr_chan.ready = 1'b1;
   assign signed_in      = csr_chan.valid ? csr_chan.signed_keys : signed_ff;

   // compares on the word just read
   assign key_le    = !key_greater(key_ff, rd_data, signed_ff);
   assign key_eq    = (rd_data == key_ff);
   assign data_gt   = key_greater(rd_data, key_ff, signed_ff);
   assign idx_last  = (({1'b0, idx_ff} + cnt_type'(1)) == count_ff);

   // binary probe: span always equals hi - lo + 1
   assign half      = span_ff >> 1;
   assign span_left = span_ff[0] ? half : (half - cnt_type'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_chan.action == ACT_INSERT) begin
                  if (count_ff >= cnt_type'(CAPACITY)) begin
                     state_in = S_RESP;
                  end else if (count_ff == '0) begin
                     state_in = S_PREP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     state_in = S_RESP;
                  end else if (count_ff < cnt_type'(LINEAR_LIMIT)) begin
                     state_in = S_LIN;
                  end else begin
                     state_in = S_PROBE_ISSUE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (key_le || idx_last) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            state_in = (at_ff == count_ff) ? S_WRITE_KEY : S_SHIFT;
         end
         S_SHIFT: begin
            if ((ptr_ff - cnt_type'(1)) == at_ff) begin
               state_in = S_WRITE_KEY;
            end
         end
         S_WRITE_KEY: begin
            state_in = S_RESP;
         end
         S_LIN: begin
            if (key_eq || idx_last) begin
               state_in = S_RESP;
            end
         end
         S_PROBE_ISSUE: begin
            state_in = (span_ff == '0) ? S_RESP : S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            state_in = (key_eq || single_ff) ? S_RESP : S_PROBE_ISSUE;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      key_in         = key_ff;
      idx_in         = idx_ff;
      at_in          = at_ff;
      ptr_in         = ptr_ff;
      lo_in          = lo_ff;
      span_in        = span_ff;
      mid_in         = mid_ff;
      single_in      = single_ff;
      count_in       = count_ff;
      res_found_in   = res_found_ff;
      res_pos_in     = res_pos_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in   = rsp_found_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      rd_addr        = '0;
      ram_wr.en      = 1'b0;
      ram_wr.addr    = at_ff[IDX_W-1:0];
      ram_wr.data    = key_ff;

      case (state_ff)
         S_IDLE: begin
            // address 0 is read here so a scan has its first word next cycle
            if (req_beat) begin
               key_in        = req_chan.key[KEY_BITS-1:0];
               idx_in        = '0;
               at_in         = '0;
               lo_in         = '0;
               span_in       = count_ff;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               res_status_in = (req_chan.action == ACT_INSERT) ? STATUS_FULL : STATUS_MISS;
            end
         end
         S_SCAN: begin
            rd_addr = idx_ff + idx_type'(1);
            idx_in  = idx_ff + idx_type'(1);
            if (key_le) begin
               at_in = {1'b0, idx_ff};
            end else if (idx_last) begin
               at_in = count_ff;
            end
         end
         S_PREP: begin
            rd_addr = idx_type'(count_ff - cnt_type'(1));
            ptr_in  = count_ff;
         end
         S_SHIFT: begin
            // move entry ptr-1 up to ptr, fetch ptr-2 for the next beat
            ram_wr.en   = 1'b1;
            ram_wr.addr = ptr_ff[IDX_W-1:0];
            ram_wr.data = rd_data;
            rd_addr     = idx_type'(ptr_ff - cnt_type'(2));
            ptr_in      = ptr_ff - cnt_type'(1);
         end
         S_WRITE_KEY: begin
            ram_wr.en     = 1'b1;
            count_in      = count_ff + cnt_type'(1);
            res_found_in  = 1'b0;
            res_pos_in    = at_ff[IDX_W-1:0];
            res_status_in = STATUS_DONE;
         end
         S_LIN: begin
            rd_addr = idx_ff + idx_type'(1);
            idx_in  = idx_ff + idx_type'(1);
            if (key_eq) begin
               res_found_in  = 1'b1;
               res_pos_in    = idx_ff;
               res_status_in = STATUS_DONE;
            end
         end
         S_PROBE_ISSUE: begin
            // single remaining entry is checked at lo itself
            single_in = (span_ff == cnt_type'(1));
            mid_in    = single_in ? lo_ff : (lo_ff + span_left);
            rd_addr   = mid_in[IDX_W-1:0];
         end
         S_PROBE_CHK: begin
            if (key_eq) begin
               res_found_in  = 1'b1;
               res_pos_in    = mid_ff[IDX_W-1:0];
               res_status_in = STATUS_DONE;
            end else if (data_gt) begin
               span_in = span_left;
            end else begin
               lo_in   = mid_ff + cnt_type'(1);
               span_in = half;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_pos_in     = res_pos_ff;
               rsp_status_in  = res_status_ff;
               rsp_entries_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      at_ff          <= at_in;
      ptr_ff         <= ptr_in;
      lo_ff          <= lo_in;
      span_ff        <= span_in;
      mid_ff         <= mid_in;
      single_ff      <= single_in;
      res_found_ff   <= res_found_in;
      res_pos_ff     <= res_pos_in;
      res_status_ff  <= res_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.entries  = rsp_entries_ff;

endmodule
